### hdl/gpid_pkg.sv
// Shared types and constants for the GPIO port interrupt detect block.
package gpid_pkg;

    localparam int PORT_W = 8;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    localparam logic [3:0] REG_DATA     = 4'd0;
    localparam logic [3:0] REG_DIR      = 4'd1;
    localparam logic [3:0] REG_SENSE    = 4'd2;
    localparam logic [3:0] REG_BOTHEDGE = 4'd3;
    localparam logic [3:0] REG_EVENT    = 4'd4;
    localparam logic [3:0] REG_MASK     = 4'd5;
    localparam logic [3:0] REG_RAW      = 4'd6;
    localparam logic [3:0] REG_MASKED   = 4'd7;
    localparam logic [3:0] REG_CLEAR    = 4'd8;
    localparam logic [3:0] REG_ALT      = 4'd9;
    localparam logic [3:0] REG_DEN      = 4'd10;
    localparam logic [3:0] REG_PULLUP   = 4'd11;
    localparam logic [3:0] REG_PULLDOWN = 4'd12;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        reg_select;
        logic [PORT_W-1:0] data_mask;
        logic [PORT_W-1:0] write_value;
        logic [PORT_W-1:0] pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [PORT_W-1:0] read_value;
        logic [PORT_W-1:0] pin_drive;
        logic [PORT_W-1:0] pin_output_enable;
        logic [PORT_W-1:0] pull_up_enable;
        logic [PORT_W-1:0] pull_down_enable;
        logic              interrupt_request;
    } t_out_item;

endpackage

### hdl/gpid_in_if.sv
// Valid/ready channel that carries one input item.
interface gpid_in_if;
    logic                valid;
    logic                ready;
    gpid_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/gpid_out_if.sv
// Valid/ready channel that carries one result item.
interface gpid_out_if;
    logic                valid;
    logic                ready;
    gpid_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/gpid_core.sv
// Port register file, pin sampling and interrupt detection for one item per cycle while i_advance is high.
module gpid_core #(
    parameter int PIN_COUNT = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  gpid_pkg::t_in_item  i_item,
    output gpid_pkg::t_out_item o_result
);
    localparam int PinBits = (PIN_COUNT < gpid_pkg::PORT_W) ? PIN_COUNT : gpid_pkg::PORT_W;
    localparam logic [gpid_pkg::PORT_W-1:0] PinMask =
        gpid_pkg::PORT_W'((64'd1 << PinBits) - 64'd1);

    logic [gpid_pkg::PORT_W-1:0] r_data, r_dir, r_sense, r_both, r_event, r_mask;
    logic [gpid_pkg::PORT_W-1:0] r_raw, r_alt, r_den, r_pu, r_pd, r_prev;
    logic [gpid_pkg::PORT_W-1:0] n_data, n_dir, n_sense, n_both, n_event, n_mask;
    logic [gpid_pkg::PORT_W-1:0] n_raw, n_alt, n_den, n_pu, n_pd, n_prev;

    logic [gpid_pkg::PORT_W-1:0] dmask, wval, pins, rd;
    logic [gpid_pkg::PORT_W-1:0] now, rise, fall, single, edge_hit, level, edge_part;

    assign dmask = i_item.data_mask & PinMask;
    assign wval  = i_item.write_value & PinMask;
    assign pins  = i_item.pin_levels & PinMask;

    // sample detection terms
    assign now       = pins & r_den;
    assign rise      = now & ~r_prev;
    assign fall      = r_prev & ~now;
    assign single    = (rise & r_event) | (fall & ~r_event);
    assign edge_hit  = (r_both & (rise | fall)) | (~r_both & single);
    assign level     = (now & r_event) | (~now & ~r_event);
    assign edge_part = (r_raw | edge_hit) & ~r_sense;

    always_comb begin
        n_data  = r_data;
        n_dir   = r_dir;
        n_sense = r_sense;
        n_both  = r_both;
        n_event = r_event;
        n_mask  = r_mask;
        n_raw   = r_raw;
        n_alt   = r_alt;
        n_den   = r_den;
        n_pu    = r_pu;
        n_pd    = r_pd;
        n_prev  = r_prev;
        rd      = '0;
        case (i_item.opcode)
            gpid_pkg::OP_READ: begin
                case (i_item.reg_select)
                    gpid_pkg::REG_DATA:
                        rd = ((r_data & r_dir) | (pins & r_den & ~r_dir)) & dmask;
                    gpid_pkg::REG_DIR:      rd = r_dir;
                    gpid_pkg::REG_SENSE:    rd = r_sense;
                    gpid_pkg::REG_BOTHEDGE: rd = r_both;
                    gpid_pkg::REG_EVENT:    rd = r_event;
                    gpid_pkg::REG_MASK:     rd = r_mask;
                    gpid_pkg::REG_RAW:      rd = r_raw;
                    gpid_pkg::REG_MASKED:   rd = r_raw & r_mask;
                    gpid_pkg::REG_ALT:      rd = r_alt;
                    gpid_pkg::REG_DEN:      rd = r_den;
                    gpid_pkg::REG_PULLUP:   rd = r_pu;
                    gpid_pkg::REG_PULLDOWN: rd = r_pd;
                    default:                rd = '0;
                endcase
            end
            gpid_pkg::OP_WRITE: begin
                case (i_item.reg_select)
                    gpid_pkg::REG_DATA:     n_data  = (r_data & ~dmask) | (wval & dmask);
                    gpid_pkg::REG_DIR:      n_dir   = wval;
                    gpid_pkg::REG_SENSE:    n_sense = wval;
                    gpid_pkg::REG_BOTHEDGE: n_both  = wval;
                    gpid_pkg::REG_EVENT:    n_event = wval;
                    gpid_pkg::REG_MASK:     n_mask  = wval;
                    gpid_pkg::REG_CLEAR:    n_raw   = r_raw & ~wval;
                    gpid_pkg::REG_ALT:      n_alt   = wval;
                    gpid_pkg::REG_DEN:      n_den   = wval;
                    // pull-up and pull-down exclude each other
                    gpid_pkg::REG_PULLUP: begin
                        n_pu = wval;
                        n_pd = r_pd & ~wval;
                    end
                    gpid_pkg::REG_PULLDOWN: begin
                        n_pd = wval;
                        n_pu = r_pu & ~wval;
                    end
                    default: ;
                endcase
            end
            gpid_pkg::OP_SAMPLE: begin
                n_raw  = edge_part | (level & r_sense);
                n_prev = now;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data  <= '0;
            r_dir   <= '0;
            r_sense <= '0;
            r_both  <= '0;
            r_event <= '0;
            r_mask  <= '0;
            r_raw   <= '0;
            r_alt   <= '0;
            r_den   <= '0;
            r_pu    <= '0;
            r_pd    <= '0;
            r_prev  <= '0;
        end else if (i_advance) begin
            r_data  <= n_data;
            r_dir   <= n_dir;
            r_sense <= n_sense;
            r_both  <= n_both;
            r_event <= n_event;
            r_mask  <= n_mask;
            r_raw   <= n_raw;
            r_alt   <= n_alt;
            r_den   <= n_den;
            r_pu    <= n_pu;
            r_pd    <= n_pd;
            r_prev  <= n_prev;
        end
    end

    // result reflects the state after this item
    always_comb begin
        o_result.read_value        = rd & PinMask;
        o_result.pin_drive         = n_data & n_dir & PinMask;
        o_result.pin_output_enable = n_dir & n_den & ~n_alt & PinMask;
        o_result.pull_up_enable    = n_pu & PinMask;
        o_result.pull_down_enable  = n_pd & PinMask;
        o_result.interrupt_request = |(n_raw & n_mask & PinMask);
    end

endmodule

### hdl/gpio_port_interrupt_detect_unit.sv
// Top level of the GPIO port with edge and level interrupt detection.
//
// Usage:
//   i_in  carries one item per handshake: a register read, a register write
//         or a pin level sample tick, selected by opcode.
//   o_out carries one result per item: read data (zero unless a read), the
//         pin drive, output enable and pull enables, and the interrupt request,
//         all as they stand after the item has taken effect.
// Path: an accepted item lands in the input register, is processed and
//   registered in the result register, and is then offered on o_out.
// Throughput: one item per cycle while o_out is not stalled; every item is
//   a few bitwise register updates done in the single stage between the
//   input and result registers.
// Stall: while o_out is stalled the result register holds and the input
//   register can still take one more item; i_in.ready drops only when both
//   are full.
// Reset: synchronous, active low; all port registers, the previous pin sample
//   and both valid flags clear to zero.
module gpio_port_interrupt_detect_unit #(
    parameter int PIN_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gpid_in_if.sink    i_in,
    gpid_out_if.source o_out
);
    logic                r_in_valid;
    gpid_pkg::t_in_item  r_in;
    logic                r_out_valid;
    gpid_pkg::t_out_item r_out;
    gpid_pkg::t_out_item result;
    logic                advance;
    logic                in_fire;

    // move the held item into the result register when that register frees
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire    = i_in.valid && i_in.ready;

    gpid_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

### sim/tb_gpio_port_interrupt_detect_unit.sv
// Testbench for the GPIO port interrupt detect unit: directed and random items, checked per result.
`timescale 1ns / 1ps

module tb_gpio_port_interrupt_detect_unit;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [3:0] REG_UNUSED_LO = 4'd13;
    localparam logic [3:0] REG_UNUSED_HI = 4'd15;
    localparam int HOLD_LEN = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gpid_in_if  in_ch ();
    gpid_out_if out_ch ();

    gpio_port_interrupt_detect_unit #(
        .PIN_COUNT(gpid_pkg::PORT_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Port state as predicted from the accepted items
    logic [gpid_pkg::PORT_W-1:0] p_data = '0, p_dir = '0, p_sense = '0, p_both = '0;
    logic [gpid_pkg::PORT_W-1:0] p_event = '0, p_mask = '0, p_raw = '0, p_alt = '0;
    logic [gpid_pkg::PORT_W-1:0] p_den = '0, p_pullup = '0, p_pulldown = '0;
    logic [gpid_pkg::PORT_W-1:0] p_prev_pins = '0;

    gpid_pkg::t_out_item pending_port_results[$];
    int fail_count = 0;
    int idle_cycles = 0;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_trigger = 0;
    int hold_taken = 0;
    int hold_left = 0;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    function automatic gpid_pkg::t_out_item predict_port_result(gpid_pkg::t_in_item it);
        gpid_pkg::t_out_item r;
        logic [gpid_pkg::PORT_W-1:0] now, rise, fall, single_hit, edge_hit, lvl_hit;
        r = '0;
        if (it.opcode == gpid_pkg::OP_READ) begin
            case (it.reg_select)
                gpid_pkg::REG_DATA: begin
                    r.read_value = ((p_data & p_dir) | (it.pin_levels & p_den & ~p_dir))
                                   & it.data_mask;
                end
                gpid_pkg::REG_DIR:      r.read_value = p_dir;
                gpid_pkg::REG_SENSE:    r.read_value = p_sense;
                gpid_pkg::REG_BOTHEDGE: r.read_value = p_both;
                gpid_pkg::REG_EVENT:    r.read_value = p_event;
                gpid_pkg::REG_MASK:     r.read_value = p_mask;
                gpid_pkg::REG_RAW:      r.read_value = p_raw;
                gpid_pkg::REG_MASKED:   r.read_value = p_raw & p_mask;
                gpid_pkg::REG_ALT:      r.read_value = p_alt;
                gpid_pkg::REG_DEN:      r.read_value = p_den;
                gpid_pkg::REG_PULLUP:   r.read_value = p_pullup;
                gpid_pkg::REG_PULLDOWN: r.read_value = p_pulldown;
                default:                r.read_value = '0;
            endcase
        end else if (it.opcode == gpid_pkg::OP_WRITE) begin
            case (it.reg_select)
                gpid_pkg::REG_DATA:
                    p_data = (p_data & ~it.data_mask) | (it.write_value & it.data_mask);
                gpid_pkg::REG_DIR:      p_dir = it.write_value;
                gpid_pkg::REG_SENSE:    p_sense = it.write_value;
                gpid_pkg::REG_BOTHEDGE: p_both = it.write_value;
                gpid_pkg::REG_EVENT:    p_event = it.write_value;
                gpid_pkg::REG_MASK:     p_mask = it.write_value;
                gpid_pkg::REG_CLEAR:    p_raw = p_raw & ~it.write_value;
                gpid_pkg::REG_ALT:      p_alt = it.write_value;
                gpid_pkg::REG_DEN:      p_den = it.write_value;
                gpid_pkg::REG_PULLUP: begin
                    p_pullup   = it.write_value;
                    p_pulldown = p_pulldown & ~it.write_value;
                end
                gpid_pkg::REG_PULLDOWN: begin
                    p_pulldown = it.write_value;
                    p_pullup   = p_pullup & ~it.write_value;
                end
                default: ;
            endcase
        end else if (it.opcode == gpid_pkg::OP_SAMPLE) begin
            now        = it.pin_levels & p_den;
            rise       = now & ~p_prev_pins;
            fall       = p_prev_pins & ~now;
            single_hit = (rise & p_event) | (fall & ~p_event);
            edge_hit   = (p_both & (rise | fall)) | (~p_both & single_hit);
            lvl_hit    = (now & p_event) | (~now & ~p_event);
            // edge pins accumulate, level pins follow the active level
            p_raw       = ((p_raw | edge_hit) & ~p_sense) | (lvl_hit & p_sense);
            p_prev_pins = now;
        end
        r.pin_drive         = p_data & p_dir;
        r.pin_output_enable = p_dir & p_den & ~p_alt;
        r.pull_up_enable    = p_pullup;
        r.pull_down_enable  = p_pulldown;
        r.interrupt_request = ((p_raw & p_mask) != '0);
        return r;
    endfunction

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_trigger != hold_taken) begin
            hold_taken   <= hold_trigger;
            hold_left    <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Check results, predict accepted items, watch for a hang
    always @(posedge i_clk) begin
        gpid_pkg::t_out_item want;
        gpid_pkg::t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_port_results.size() == 0) begin
                $error("result with no item outstanding: %h", got);
                fail_count++;
            end else begin
                want = pending_port_results.pop_front();
                if (got.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                    fail_count++;
                end
                if (got.pin_drive !== want.pin_drive) begin
                    $error("pin_drive: expected %h, got %h", want.pin_drive, got.pin_drive);
                    fail_count++;
                end
                if (got.pin_output_enable !== want.pin_output_enable) begin
                    $error("pin_output_enable: expected %h, got %h",
                           want.pin_output_enable, got.pin_output_enable);
                    fail_count++;
                end
                if (got.pull_up_enable !== want.pull_up_enable) begin
                    $error("pull_up_enable: expected %h, got %h",
                           want.pull_up_enable, got.pull_up_enable);
                    fail_count++;
                end
                if (got.pull_down_enable !== want.pull_down_enable) begin
                    $error("pull_down_enable: expected %h, got %h",
                           want.pull_down_enable, got.pull_down_enable);
                    fail_count++;
                end
                if (got.interrupt_request !== want.interrupt_request) begin
                    $error("interrupt_request: expected %b, got %b",
                           want.interrupt_request, got.interrupt_request);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready)
            pending_port_results.push_back(predict_port_result(in_ch.data));

        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("gpio_port_interrupt_detect_unit verification failed");
            $finish;
        end
    end

    task automatic send_item(gpid_pkg::t_in_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_op(logic [1:0] op, logic [3:0] sel,
                           logic [gpid_pkg::PORT_W-1:0] dmask,
                           logic [gpid_pkg::PORT_W-1:0] wval,
                           logic [gpid_pkg::PORT_W-1:0] pins);
        gpid_pkg::t_in_item it;
        it.opcode      = op;
        it.reg_select  = sel;
        it.data_mask   = dmask;
        it.write_value = wval;
        it.pin_levels  = pins;
        send_item(it);
    endtask

    function automatic gpid_pkg::t_in_item random_port_item();
        gpid_pkg::t_in_item it;
        int pick;
        it.data_mask   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        it.write_value = 8'($urandom);
        it.pin_levels  = 8'($urandom);
        it.reg_select  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 12));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.opcode = gpid_pkg::OP_SAMPLE;
        else if (pick < 70)
            it.opcode = gpid_pkg::OP_WRITE;
        else if (pick < 95)
            it.opcode = gpid_pkg::OP_READ;
        else
            it.opcode = OP_UNUSED;
        // keep the mask and enables open often enough to raise interrupts
        if (it.opcode == gpid_pkg::OP_WRITE
            && (it.reg_select == gpid_pkg::REG_MASK || it.reg_select == gpid_pkg::REG_DEN)
            && $urandom_range(0, 1) == 0)
            it.write_value = 8'hFF;
        return it;
    endfunction

    task automatic set_idling(int src_pct, int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    task automatic test_register_access();
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_DEN, 8'h00, 8'hFF, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_DIR, 8'h00, 8'h0F, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_DATA, 8'h3C, 8'hFF, 8'h00);
        send_op(gpid_pkg::OP_READ, gpid_pkg::REG_DATA, 8'hFF, 8'h00, 8'hA5);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_ALT, 8'h00, 8'h03, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_PULLUP, 8'h00, 8'hFF, 8'h00);
        // pull-down ones drop the matching pull-up bits
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_PULLDOWN, 8'h00, 8'h0F, 8'h00);
        send_op(gpid_pkg::OP_READ, gpid_pkg::REG_PULLUP, 8'h00, 8'h00, 8'h00);
        send_op(gpid_pkg::OP_WRITE, REG_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF);
        send_op(gpid_pkg::OP_READ, REG_UNUSED_LO, 8'hFF, 8'h00, 8'hFF);
        send_op(OP_UNUSED, REG_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_interrupt_detect();
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_EVENT, 8'h00, 8'hF0, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_BOTHEDGE, 8'h00, 8'h0C, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_SENSE, 8'h00, 8'hC0, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_MASK, 8'h00, 8'hFF, 8'h00);
        send_op(gpid_pkg::OP_SAMPLE, gpid_pkg::REG_DATA, 8'h00, 8'h00, 8'hFF);
        send_op(gpid_pkg::OP_SAMPLE, gpid_pkg::REG_DATA, 8'h00, 8'h00, 8'h00);
        send_op(gpid_pkg::OP_READ, gpid_pkg::REG_RAW, 8'h00, 8'h00, 8'h00);
        // status registers are read-only
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_RAW, 8'h00, 8'hFF, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_MASKED, 8'h00, 8'hFF, 8'h00);
        send_op(gpid_pkg::OP_READ, gpid_pkg::REG_MASKED, 8'h00, 8'h00, 8'h00);
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_CLEAR, 8'h00, 8'h0F, 8'h00);
        send_op(gpid_pkg::OP_READ, gpid_pkg::REG_CLEAR, 8'h00, 8'h00, 8'h00);
        // with digital enable off the pins read and sample as low
        send_op(gpid_pkg::OP_WRITE, gpid_pkg::REG_DEN, 8'h00, 8'h00, 8'h00);
        send_op(gpid_pkg::OP_SAMPLE, gpid_pkg::REG_DATA, 8'h00, 8'h00, 8'hFF);
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_item(random_port_item());
    endtask

    task automatic test_output_stall();
        int saved_src;
        saved_src = src_idle_pct;
        src_idle_pct = 0;
        hold_trigger <= hold_trigger + 1;
        repeat (24) send_item(random_port_item());
        src_idle_pct = saved_src;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(15, 53);
        test_register_access();
        test_interrupt_detect();
        test_random_mix(170);
        test_output_stall();

        set_idling(53, 15);
        test_random_mix(170);

        set_idling(0, 0);
        test_random_mix(170);

        in_ch.valid <= 1'b0;
        while (pending_port_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("gpio_port_interrupt_detect_unit verification clean");
        else
            $display("gpio_port_interrupt_detect_unit verification failed");
        $finish;
    end

endmodule
